/* hw/rtl/iqba_pkg.sv */
`timescale 1ns / 1ps

package iqba_pkg;

    // Fixed-point format and path limits
    localparam int FRAC_BITS    = 28;
    localparam int DATA_W       = 32;
    localparam int MAX_PATH_LEN = 8;
    localparam int LEN_W        = 4;
    localparam int IDX_W        = $clog2(MAX_PATH_LEN);
    localparam int PROD_W       = 2 * DATA_W;

    typedef logic signed [DATA_W-1:0] q_t;

    // Q3.28 constants, from square roots at 32 fraction bits, rounded half up
    localparam q_t Q_ONE       = q_t'(1) <<< FRAC_BITS;
    localparam q_t Q_HALF      = q_t'(1) <<< (FRAC_BITS - 1);
    localparam q_t Q_PHI       = 32'sd165902236;
    localparam q_t Q_ROOT      = 32'sd211030904;
    localparam q_t Q_D0_RE     = -32'sd217168846;
    localparam q_t Q_D0_IM     = -32'sd157782402;
    localparam q_t Q_D1_RE     = -32'sd82951118;
    localparam q_t Q_D1_IM     = 32'sd255297290;
    localparam q_t Q_B01_RE    = -32'sd65212136;
    localparam q_t Q_B01_IM    = -32'sd200702316;
    localparam q_t Q_B00_IM    = 32'sd97514887;

    // Braid table index codes: {left_label, p0, old_end, new_end}
    localparam logic [3:0] BR_D0   = 4'b0011;
    localparam logic [3:0] BR_D1A  = 4'b0111;
    localparam logic [3:0] BR_D1B  = 4'b1011;
    localparam logic [3:0] BR_B00  = 4'b1100;
    localparam logic [3:0] BR_B01A = 4'b1101;
    localparam logic [3:0] BR_B01B = 4'b1110;
    localparam logic [3:0] BR_B11  = 4'b1111;

    typedef struct packed {
        logic                outer_root;
        logic                prev_root;
        logic                prev_prev_root;
        logic                new_prev_root;
        logic                left_label;
        logic                new_end_label;
        logic                old_end_label;
        logic [LEN_W-1:0]    path_length;
        logic [MAX_PATH_LEN-1:0] new_path_bits;
        logic [MAX_PATH_LEN-1:0] old_path_bits;
    } iqba_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] amplitude_real;
        logic signed [DATA_W-1:0] amplitude_imag;
        logic                     saturated;
    } iqba_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OUTER,
        ST_STEP,
        ST_BRE,
        ST_BRE2,
        ST_BIM,
        ST_BIM2,
        ST_NEXT,
        ST_DONE
    } iqba_state_t;

    // F-symbol entry [row][col] for labels a1, a2, a3, o
    function automatic q_t f_entry(logic a1, logic a2, logic a3, logic o,
                                   logic row, logic col);
        logic [2:0] s;
        logic       pr;
        logic       pc;
        q_t         r;
        s  = 3'(a1) + 3'(a2) + 3'(a3) + 3'(o);
        pr = 1'b1;
        pc = 1'b1;
        r  = '0;
        case (s)
            3'd4:
            begin
                if (row != col)
                    r = Q_ROOT;
                else
                    r = row ? -Q_PHI : Q_PHI;
            end
            3'd3:
            begin
                r = (row && col) ? Q_ONE : '0;
            end
            3'd2:
            begin
                if (a1 && a2)
                begin
                    pr = 1'b0;
                    pc = 1'b1;
                end
                else if (a2 && a3)
                begin
                    pr = 1'b1;
                    pc = 1'b0;
                end
                else if (a1 && a3)
                begin
                    pr = 1'b1;
                    pc = 1'b1;
                end
                else if (a3 && o)
                begin
                    pr = 1'b0;
                    pc = 1'b1;
                end
                else if (a1 && o)
                begin
                    pr = 1'b1;
                    pc = 1'b0;
                end
                r = (row == pr && col == pc) ? Q_ONE : '0;
            end
            default:
            begin
                r = (!row && !col) ? Q_ONE : '0;
            end
        endcase
        return r;
    endfunction

    // Real part of the braid entry B = F*R*F^T
    function automatic q_t braid_re(logic [3:0] idx);
        q_t r;
        unique case (idx)
            BR_D0:              r = Q_D0_RE;
            BR_D1A, BR_D1B:     r = Q_D1_RE;
            BR_B00:             r = -Q_HALF;
            BR_B01A, BR_B01B:   r = Q_B01_RE;
            BR_B11:             r = -Q_PHI;
            default:            r = '0;
        endcase
        return r;
    endfunction

    // Imaginary part of the braid entry
    function automatic q_t braid_im(logic [3:0] idx);
        q_t r;
        unique case (idx)
            BR_D0:              r = Q_D0_IM;
            BR_D1A, BR_D1B:     r = Q_D1_IM;
            BR_B00:             r = Q_B00_IM;
            BR_B01A, BR_B01B:   r = Q_B01_IM;
            default:            r = '0;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/inter_qudit_braid_amplitude.sv */
`timescale 1ns / 1ps

// Braid amplitude between neighbouring qudits.
// Input channel (in_valid / in_ready / in_data) takes one word of fusion
// labels and path bits; output channel (out_valid / out_ready / out_data)
// returns one word with the complex Q3.28 amplitude and a saturation flag.
// One shared Q3.28 multiplier does all products under a small sequencer:
// per outer bit with nonzero outer F entries, every path p of the clamped
// length L (1..8) takes multiply steps over each position, old path then new
// path, then the braid/accumulate steps and advance; a zero F factor ends its
// path early and unit factors pass through without changing the term.
// in_ready is high only while the sequencer is idle; one word at a time:
// a new word is taken only after the previous one is finished.
// The finished word sits in an output register, so the next input word is
// taken while the previous result still waits; if the receiver stalls and
// the register is full, the sequencer holds in its done state.
// Reset clears the sequencer and the output valid; no memory to clear.
module inter_qudit_braid_amplitude
    import iqba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  iqba_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output iqba_out_t out_data
);

    iqba_state_t           state_reg, state_next;
    iqba_in_t              in_reg, in_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic                  kk_reg, kk_next;
    logic [MAX_PATH_LEN-1:0] p_reg, p_next;
    logic [IDX_W-1:0]      n_reg, n_next;
    logic                  ph_reg, ph_next;
    q_t                    t_reg, t_next;
    q_t                    prod_reg, prod_next;
    q_t                    fo1_reg, fo1_next;
    q_t                    fo2_reg, fo2_next;
    q_t                    acc_re_reg, acc_re_next;
    q_t                    acc_im_reg, acc_im_next;
    logic                  sat_reg, sat_next;
    logic                  out_valid_reg, out_valid_next;
    iqba_out_t             out_reg, out_next;

    q_t                    mul_a;
    q_t                    mul_b;
    q_t                    mul_y;
    q_t                    fo1_c;
    q_t                    fo2_c;
    q_t                    factor;
    logic [IDX_W-1:0]      last_idx;
    logic [LEN_W-1:0]      n_plus;
    logic                  pn;
    logic                  pnext;
    logic                  prev_lbl;
    logic                  cur_lbl;
    logic                  end_lbl;
    logic [MAX_PATH_LEN:0] p_mask;
    logic                  p_last;
    logic [3:0]            br_idx;
    logic [DATA_W:0]       sum_w;
    logic                  sum_ovf;
    q_t                    sum_sat;
    q_t                    acc_sel;
    logic [LEN_W-1:0]      len_clamp;

    // shared multiply unit
    iqba_mul u_mul
    (
        .a (mul_a),
        .b (mul_b),
        .y (mul_y)
    );

    // path length clamped to 1..MAX_PATH_LEN
    always_comb
    begin
        if (in_data.path_length == '0)
            len_clamp = LEN_W'(1);
        else if (in_data.path_length > LEN_W'(MAX_PATH_LEN))
            len_clamp = LEN_W'(MAX_PATH_LEN);
        else
            len_clamp = in_data.path_length;
    end

    // outer F entries for the current outer bit
    assign last_idx = IDX_W'(len_reg - LEN_W'(1));
    assign fo1_c = f_entry(in_reg.prev_prev_root, in_reg.old_end_label,
                           in_reg.old_path_bits[last_idx], in_reg.outer_root,
                           in_reg.prev_root, kk_reg);
    assign fo2_c = f_entry(in_reg.prev_prev_root, in_reg.new_end_label,
                           in_reg.new_path_bits[last_idx], in_reg.outer_root,
                           in_reg.new_prev_root, kk_reg);

    // per-position F factor: phase 0 uses the old path, phase 1 the new one
    assign n_plus = LEN_W'(n_reg) + LEN_W'(1);
    assign pn     = p_reg[n_reg];
    assign pnext  = (n_plus < len_reg) ? p_reg[n_plus[IDX_W-1:0]] : kk_reg;
    always_comb
    begin
        if (n_reg == '0)
            prev_lbl = 1'b1;
        else if (ph_reg)
            prev_lbl = in_reg.new_path_bits[n_reg - IDX_W'(1)];
        else
            prev_lbl = in_reg.old_path_bits[n_reg - IDX_W'(1)];
    end
    assign cur_lbl = ph_reg ? in_reg.new_path_bits[n_reg] : in_reg.old_path_bits[n_reg];
    assign end_lbl = ph_reg ? in_reg.new_end_label : in_reg.old_end_label;
    assign factor  = f_entry(end_lbl, prev_lbl, 1'b1, pnext, pn, cur_lbl);

    // last path of this outer bit
    assign p_mask = ((MAX_PATH_LEN + 1)'(1) << len_reg) - (MAX_PATH_LEN + 1)'(1);
    assign p_last = (p_reg == p_mask[MAX_PATH_LEN-1:0]);

    assign br_idx = {in_reg.left_label, p_reg[0], in_reg.old_end_label,
                     in_reg.new_end_label};

    // saturating accumulate of the unit result
    assign acc_sel = (state_reg == ST_BIM2) ? acc_im_reg : acc_re_reg;
    assign sum_w   = {acc_sel[DATA_W-1], acc_sel} + {mul_y[DATA_W-1], mul_y};
    assign sum_ovf = sum_w[DATA_W] != sum_w[DATA_W-1];
    always_comb
    begin
        if (!sum_ovf)
            sum_sat = q_t'(sum_w[DATA_W-1:0]);
        else if (sum_w[DATA_W])
            sum_sat = {1'b1, {(DATA_W-1){1'b0}}};
        else
            sum_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = t_reg;
        mul_b = factor;
        unique case (state_reg)
            ST_BRE:
            begin
                mul_b = braid_re(br_idx);
            end
            ST_BIM:
            begin
                mul_b = braid_im(br_idx);
            end
            ST_BRE2, ST_BIM2:
            begin
                mul_a = prod_reg;
                mul_b = fo2_reg;
            end
            default:
            begin
                mul_a = t_reg;
                mul_b = factor;
            end
        endcase
    end

    // sequencer: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        in_next        = in_reg;
        len_next       = len_reg;
        kk_next        = kk_reg;
        p_next         = p_reg;
        n_next         = n_reg;
        ph_next        = ph_reg;
        t_next         = t_reg;
        prod_next      = prod_reg;
        fo1_next       = fo1_reg;
        fo2_next       = fo2_reg;
        acc_re_next    = acc_re_reg;
        acc_im_next    = acc_im_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        in_ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    in_next     = in_data;
                    len_next    = len_clamp;
                    kk_next     = 1'b0;
                    acc_re_next = '0;
                    acc_im_next = '0;
                    sat_next    = 1'b0;
                    state_next  = ST_OUTER;
                end
            end
            ST_OUTER:
            begin
                fo1_next = fo1_c;
                fo2_next = fo2_c;
                p_next   = '0;
                n_next   = '0;
                ph_next  = 1'b0;
                t_next   = fo1_c;
                if (fo1_c == '0 || fo2_c == '0)
                begin
                    if (kk_reg)
                        state_next = ST_DONE;
                    else
                        kk_next = 1'b1;
                end
                else
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (factor == '0)
                begin
                    t_next     = '0;
                    state_next = ST_NEXT;
                end
                else
                begin
                    if (factor != Q_ONE)
                        t_next = mul_y;
                    ph_next = !ph_reg;
                    if (ph_reg)
                    begin
                        if (n_plus == len_reg)
                            state_next = ST_BRE;
                        else
                            n_next = n_plus[IDX_W-1:0];
                    end
                end
            end
            ST_BRE:
            begin
                prod_next  = mul_y;
                state_next = ST_BRE2;
            end
            ST_BRE2:
            begin
                acc_re_next = sum_sat;
                sat_next    = sat_reg | sum_ovf;
                state_next  = ST_BIM;
            end
            ST_BIM:
            begin
                prod_next  = mul_y;
                state_next = ST_BIM2;
            end
            ST_BIM2:
            begin
                acc_im_next = sum_sat;
                sat_next    = sat_reg | sum_ovf;
                state_next  = ST_NEXT;
            end
            ST_NEXT:
            begin
                n_next  = '0;
                ph_next = 1'b0;
                t_next  = fo1_reg;
                if (p_last)
                begin
                    if (kk_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        kk_next    = 1'b1;
                        state_next = ST_OUTER;
                    end
                end
                else
                begin
                    p_next     = p_reg + MAX_PATH_LEN'(1);
                    state_next = ST_STEP;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next          = 1'b1;
                    out_next.amplitude_real = acc_re_reg;
                    out_next.amplitude_imag = acc_im_reg;
                    out_next.saturated      = sat_reg;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        in_reg     <= in_next;
        len_reg    <= len_next;
        kk_reg     <= kk_next;
        p_reg      <= p_next;
        n_reg      <= n_next;
        ph_reg     <= ph_next;
        t_reg      <= t_next;
        prod_reg   <= prod_next;
        fo1_reg    <= fo1_next;
        fo2_reg    <= fo2_next;
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
        sat_reg    <= sat_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // an accepted word makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready stayed high after accepting a word");

    // a finished result always lands in the output register
    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && (!out_valid_reg || out_ready) |=> out_valid_reg)
        else $error("done state did not load the output register");

    // path position stays inside the clamped length while stepping
    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STEP |-> LEN_W'(n_reg) < len_reg && len_reg != '0)
        else $error("path position beyond path length");

    // braid steps only start on the new-path phase of the last position
    a_braid_entry: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STEP && state_next == ST_BRE |-> ph_reg && n_plus == len_reg)
        else $error("braid step entered before the path was finished");

endmodule

/* hw/rtl/iqba_mul.sv */
`timescale 1ns / 1ps

// Q3.28 multiply, rounded half away from zero (sign-magnitude)
module iqba_mul
    import iqba_pkg::*;
(
    input  q_t a,
    input  q_t b,
    output q_t y
);

    logic                neg;
    logic [DATA_W-1:0]   mag_a;
    logic [DATA_W-1:0]   mag_b;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   prod_rnd;
    logic [DATA_W-1:0]   mag_y;

    // magnitudes; -2^31 still fits as unsigned
    assign neg   = a[DATA_W-1] ^ b[DATA_W-1];
    assign mag_a = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
    assign mag_b = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);

    // exact product, round, drop fraction bits
    assign prod     = PROD_W'(mag_a) * PROD_W'(mag_b);
    assign prod_rnd = prod + (PROD_W'(1) << (FRAC_BITS - 1));
    assign mag_y    = prod_rnd[FRAC_BITS +: DATA_W];

    assign y = neg ? -q_t'(mag_y) : q_t'(mag_y);

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
    import iqba_pkg::*;

    localparam int FRAC_W     = 28;
    localparam int PATH_MAX   = 8;
    localparam int IN_W       = $bits(iqba_in_t);
    localparam int QUIET_MAX  = 200000;
    localparam int HOLD_AT    = 40;
    localparam int HOLD_LEN   = 25000;
    localparam int CALM_LO    = 80;
    localparam int CALM_HI    = 110;
    localparam int IDLE_PCT   = 6;
    localparam int N_RANDOM   = 106;
    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -64'sd2147483648;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid = 1'b0;
    logic      in_ready;
    iqba_in_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    iqba_out_t out_data;

    // label words waiting to be offered, amplitudes waiting to come back
    iqba_in_t  label_words[$];
    iqba_out_t expected_amps[$];

    // Q3.28 constants of the predictor: phi, sqrt(phi), braid entries
    longint    k_phi;
    longint    k_root;
    longint    br_re[16];
    longint    br_im[16];

    int        words_in = 0;
    int        amps_out = 0;
    int        mismatches = 0;
    int        stall_left = 0;
    bit        hold_done = 1'b0;
    int        quiet_cycles = 0;

    inter_qudit_braid_amplitude dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // floor(sqrt(x * 2^32)), digit by digit
    function automatic logic [63:0] sqrt_q32(logic [63:0] x);
        logic [127:0] v;
        logic [127:0] rem;
        logic [127:0] trial;
        logic [63:0]  root;
        v    = {64'd0, x} << 32;
        rem  = '0;
        root = '0;
        for (int q = 47; q >= 0; q--)
        begin
            rem   = (rem << 2) | ((v >> (2 * q)) & 128'd3);
            trial = ({64'd0, root} << 2) | 128'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    function automatic longint round_shift(logic [63:0] v, int s);
        return longint'((v + (64'd1 << (s - 1))) >> s);
    endfunction

    task automatic build_constants();
        logic [63:0] one;
        logic [63:0] s5;
        one = 64'd1 << 32;
        s5  = sqrt_q32(5 * one);
        k_phi  = round_shift(s5 - one, 5);
        k_root = round_shift(sqrt_q32((s5 - one) >> 1), 4);
        for (int i = 0; i < 16; i++)
        begin
            br_re[i] = 0;
            br_im[i] = 0;
        end
        // index is {left_label, p0, old_end, new_end}
        br_re[4'b0011] = -round_shift(s5 + one, 6);
        br_im[4'b0011] = -round_shift(sqrt_q32(10 * one - 2 * s5), 6);
        br_re[4'b0111] = -round_shift(s5 - one, 6);
        br_im[4'b0111] = round_shift(sqrt_q32(10 * one + 2 * s5), 6);
        br_re[4'b1011] = br_re[4'b0111];
        br_im[4'b1011] = br_im[4'b0111];
        br_re[4'b1100] = -(64'sd1 << (FRAC_W - 1));
        br_im[4'b1100] = round_shift(sqrt_q32(5 * one - 2 * s5), 5);
        br_re[4'b1101] = -round_shift(sqrt_q32(s5 - 2 * one), 5);
        br_im[4'b1101] = -round_shift(sqrt_q32(s5), 5);
        br_re[4'b1110] = br_re[4'b1101];
        br_im[4'b1110] = br_im[4'b1101];
        br_re[4'b1111] = -k_phi;
    endtask

    // fixed-point product, rounded half away from zero
    function automatic longint q_mul(longint a, longint b);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] mag;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        mag = ({64'd0, ua} * {64'd0, ub} + (128'd1 << (FRAC_W - 1))) >> FRAC_W;
        if (mag > 128'h7FFF_FFFF_FFFF_FFFF)
            mag = 128'h7FFF_FFFF_FFFF_FFFF;
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    // F-symbol entry [row][col] for fusion labels a1, a2, a3, o
    function automatic longint fsym(bit a1, bit a2, bit a3, bit o, bit row, bit col);
        int     s;
        bit     pr;
        bit     pc;
        longint one;
        s   = int'(a1) + int'(a2) + int'(a3) + int'(o);
        one = 64'sd1 << FRAC_W;
        if (s == 4)
        begin
            if (row != col)
                return k_root;
            return row ? -k_phi : k_phi;
        end
        if (s == 3)
            return (row && col) ? one : 0;
        if (s == 2)
        begin
            if (a1 && a2)      begin pr = 0; pc = 1; end
            else if (a2 && a3) begin pr = 1; pc = 0; end
            else if (a1 && a3) begin pr = 1; pc = 1; end
            else if (a3 && o)  begin pr = 0; pc = 1; end
            else if (a1 && o)  begin pr = 1; pc = 0; end
            else               begin pr = 1; pc = 1; end
            return (row == pr && col == pc) ? one : 0;
        end
        return (!row && !col) ? one : 0;
    endfunction

    function automatic longint clip_add(longint acc, longint v, inout bit clipped);
        longint s;
        s = acc + v;
        if (s > SUM_MAX)
        begin
            clipped = 1'b1;
            return SUM_MAX;
        end
        if (s < SUM_MIN)
        begin
            clipped = 1'b1;
            return SUM_MIN;
        end
        return s;
    endfunction

    // amplitude for one label word: sum over outer bit and every path
    function automatic iqba_out_t braid_amplitude(iqba_in_t w);
        iqba_out_t  r;
        int         len;
        longint     acc_re;
        longint     acc_im;
        longint     t;
        longint     fo1;
        longint     fo2;
        bit         clipped;
        bit         pn;
        bit         pnext;
        bit         oprev;
        bit         nprev;
        logic [3:0] bidx;
        len = int'(w.path_length);
        if (len < 1)
            len = 1;
        if (len > PATH_MAX)
            len = PATH_MAX;
        acc_re  = 0;
        acc_im  = 0;
        clipped = 1'b0;
        for (int kk = 0; kk < 2; kk++)
        begin
            fo1 = fsym(w.prev_prev_root, w.old_end_label, w.old_path_bits[len-1],
                       w.outer_root, w.prev_root, kk[0]);
            fo2 = fsym(w.prev_prev_root, w.new_end_label, w.new_path_bits[len-1],
                       w.outer_root, w.new_prev_root, kk[0]);
            if (fo1 == 0 || fo2 == 0)
                continue;
            for (int p = 0; p < (1 << len); p++)
            begin
                t = fo1;
                for (int n = 0; n < len && t != 0; n++)
                begin
                    pn    = p[n];
                    pnext = (n + 1 < len) ? p[n+1] : kk[0];
                    oprev = (n == 0) ? 1'b1 : w.old_path_bits[n-1];
                    nprev = (n == 0) ? 1'b1 : w.new_path_bits[n-1];
                    t = q_mul(t, fsym(w.old_end_label, oprev, 1'b1, pnext, pn,
                                      w.old_path_bits[n]));
                    t = q_mul(t, fsym(w.new_end_label, nprev, 1'b1, pnext, pn,
                                      w.new_path_bits[n]));
                end
                if (t == 0)
                    continue;
                bidx   = {w.left_label, p[0], w.old_end_label, w.new_end_label};
                acc_re = clip_add(acc_re, q_mul(q_mul(t, br_re[bidx]), fo2), clipped);
                acc_im = clip_add(acc_im, q_mul(q_mul(t, br_im[bidx]), fo2), clipped);
            end
        end
        r.amplitude_real = acc_re[31:0];
        r.amplitude_imag = acc_im[31:0];
        r.saturated      = clipped;
        return r;
    endfunction

    // mostly short paths; a few of length zero (clamped to one) or at or past the maximum
    function automatic logic [3:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 4'($urandom_range(8, 15));
        if (r < 5)
            return 4'd0;
        if (r < 15)
            return 4'($urandom_range(5, 7));
        return 4'($urandom_range(1, 4));
    endfunction

    function automatic iqba_in_t random_word();
        iqba_in_t w;
        bit       want_live;
        iqba_out_t a;
        want_live = $urandom_range(0, 99) < 75;
        for (int tries = 0; tries < 16; tries++)
        begin
            w = IN_W'($urandom);
            w.path_length = pick_length();
            if (!want_live)
                break;
            a = braid_amplitude(w);
            if (a.amplitude_real != 0 || a.amplitude_imag != 0)
                break;
        end
        return w;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // driver: offer queued words, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_amps = {expected_amps, braid_amplitude(in_data)};
                words_in++;
            end
            if (!in_valid || in_ready)
            begin
                if (label_words.size() != 0 &&
                    ((words_in >= CALM_LO && words_in < CALM_HI) ||
                     $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    in_data  <= label_words.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: check results, random stalls and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        iqba_out_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_amps.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected amplitude: expected none actual re=%0d im=%0d sat=%0d",
                             $time, out_data.amplitude_real, out_data.amplitude_imag,
                             out_data.saturated);
                end
                else
                begin
                    want = expected_amps.pop_front();
                    check_field("amplitude_real", want.amplitude_real, out_data.amplitude_real);
                    check_field("amplitude_imag", want.amplitude_imag, out_data.amplitude_imag);
                    check_field("saturated", want.saturated, out_data.saturated);
                end
                amps_out++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (amps_out == HOLD_AT && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_LEN - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= (amps_out >= CALM_LO && amps_out < CALM_HI) ||
                             ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("status: fail");
                $finish;
            end
        end
        else
            quiet_cycles <= 0;
    end

    initial
    begin
        iqba_in_t w;
        rst_n = 1'b0;
        build_constants();

        // every braid table corner, short paths
        for (int i = 0; i < 16; i++)
        begin
            w = '0;
            w.left_label     = i[3];
            w.old_end_label  = i[2];
            w.new_end_label  = i[1];
            w.outer_root     = i[0];
            w.prev_root      = 1'b1;
            w.new_prev_root  = 1'b1;
            w.prev_prev_root = i[0] ^ i[3];
            w.path_length    = 4'd2;
            w.old_path_bits  = 8'(i * 37);
            w.new_path_bits  = 8'(i * 91);
            label_words = {label_words, w};
        end
        // field extremes, zero length and lengths past the maximum
        w = '0;
        label_words = {label_words, w};
        w = '1;
        label_words = {label_words, w};
        w = '1;
        w.path_length   = 4'd8;
        w.old_path_bits = 8'hAA;
        w.new_path_bits = 8'h55;
        label_words = {label_words, w};
        w = {7'b1010101, 4'd9, 8'h55, 8'hAA};
        label_words = {label_words, w};
        w = {7'b1111111, 4'd1, 8'h00, 8'hFF};
        label_words = {label_words, w};
        w = {7'b0000000, 4'd1, 8'hFF, 8'h00};
        label_words = {label_words, w};
        w = {7'b0110110, 4'd3, 8'h80, 8'h01};
        label_words = {label_words, w};
        w = {7'b1001011, 4'd8, 8'h00, 8'h00};
        label_words = {label_words, w};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // sender pause: let every directed amplitude come back first
        while (label_words.size() != 0 || in_valid || expected_amps.size() != 0)
            @(posedge clk);

        for (int i = 0; i < N_RANDOM; i++)
            label_words = {label_words, random_word()};

        while (label_words.size() != 0 || in_valid || expected_amps.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
